// ----- sv/pdoq_pkg.sv -----
package pdoq_pkg;

  localparam int COORD_W = 5;
  localparam int HEIGHT_W = 16;
  localparam int COEF_W = 32;
  localparam int DEPTH_W = 48;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_H = 2'd2;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROP_FULL = 2'd3;

  typedef struct packed {
    logic [COEF_W-1:0] cx;
    logic [COEF_W-1:0] cy;
    logic [COEF_W-1:0] ch;
  } coef_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- sv/pdoq_depth.sv -----
module pdoq_depth (
  input  logic                                clk,
  input  logic                                load_en,
  input  logic                                sum_en,
  input  pdoq_pkg::coef_t                     coef,
  input  logic [pdoq_pkg::COORD_W-1:0]        cell_x,
  input  logic [pdoq_pkg::COORD_W-1:0]        cell_y,
  input  logic [pdoq_pkg::HEIGHT_W-1:0]       height,
  output logic [pdoq_pkg::DEPTH_W-1:0]        depth
);

  localparam int PXY_W = pdoq_pkg::COEF_W + pdoq_pkg::COORD_W + 2;
  localparam int PH_W = pdoq_pkg::COEF_W + pdoq_pkg::HEIGHT_W;
  localparam int DW = pdoq_pkg::DEPTH_W;

  logic signed [PXY_W-1:0] prod_x_r, prod_x_nxt;
  logic signed [PXY_W-1:0] prod_y_r, prod_y_nxt;
  logic signed [PH_W-1:0]  prod_h_r, prod_h_nxt;
  logic [DW-1:0]           depth_r, depth_nxt;

  // 2x+1 is the cell centre at twice the scale
  always_comb begin
    prod_x_nxt = $signed(coef.cx) * $signed({1'b0, cell_x, 1'b1});
    prod_y_nxt = $signed(coef.cy) * $signed({1'b0, cell_y, 1'b1});
    prod_h_nxt = $signed(coef.ch) * $signed(height);
  end

  always_comb begin
    depth_nxt = {{(DW-PXY_W){prod_x_r[PXY_W-1]}}, prod_x_r}
              + {{(DW-PXY_W){prod_y_r[PXY_W-1]}}, prod_y_r}
              + DW'(prod_h_r);
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      prod_h_r <= prod_h_nxt;
    end
    if (sum_en) begin
      depth_r <= depth_nxt;
    end
  end

  assign depth = depth_r;

endmodule

// ----- sv/pdoq_cell.sv -----
module pdoq_cell #(
  parameter int RASTER_W = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdoq_pkg::cell_ctl_t  ctl,
  input  pdoq_pkg::entry_t     new_ent,
  input  logic [RASTER_W-1:0]  new_ras,
  input  logic                 prev_flag,
  input  logic                 prev_valid,
  input  pdoq_pkg::entry_t     prev_ent,
  input  logic [RASTER_W-1:0]  prev_ras,
  input  logic                 next_valid,
  input  pdoq_pkg::entry_t     next_ent,
  input  logic [RASTER_W-1:0]  next_ras,
  output logic                 flag,
  output logic                 valid,
  output pdoq_pkg::entry_t     ent,
  output logic [RASTER_W-1:0]  ras
);

  logic                valid_r, valid_nxt;
  pdoq_pkg::entry_t    ent_r, ent_nxt;
  logic [RASTER_W-1:0] ras_r, ras_nxt;

  // new entry goes ahead of this slot: empty, deeper, or same depth and lower raster
  assign flag = !valid_r
             || ($signed(new_ent.depth) > $signed(ent_r.depth))
             || ((new_ent.depth == ent_r.depth) && (new_ras < ras_r));

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt = ent_r;
    ras_nxt = ras_r;
    if (ctl.insert && flag) begin
      if (prev_flag) begin
        valid_nxt = prev_valid;
        ent_nxt = prev_ent;
        ras_nxt = prev_ras;
      end else begin
        valid_nxt = 1'b1;
        ent_nxt = new_ent;
        ras_nxt = new_ras;
      end
    end else if (ctl.pop) begin
      valid_nxt = next_valid;
      ent_nxt = next_ent;
      ras_nxt = next_ras;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    ras_r <= ras_nxt;
  end

  assign valid = valid_r;
  assign ent = ent_r;
  assign ras = ras_r;

endmodule

// ----- sv/painter_depth_order_queue_unit.sv -----
// Painter-order queue for terrain cells.
// Input channel (in_valid/in_stall) carries one request per beat: an insert of
// a cell (x, y, centre height) or a pop of the next cell in painter order,
// deepest first, ties broken by the lower raster index y*GRID_SIDE+x, full
// ties in insertion order.
// Result channel (out_valid/out_stall) returns one beat per request with a
// status and, on a pop, the cell and its depth in units of 2^-17.
// cfg_we/cfg_index/cfg_data write the three depth coefficients; write only
// while the queue is idle.
// From accept to out_valid a request passes products, sum, then the cell
// row shift. The next request is taken only after the previous one has
// left the two-stage depth unit for the row update.
// While a result waits under out_stall the next request is still taken and
// carried through the depth stages; it waits in the sum stage until the
// output register frees up, and in_stall stays high meanwhile.
// Synchronous reset clears every cell's valid bit, the entry count, the
// coefficients and the handshake state; the queue is usable the next cycle.
module painter_depth_order_queue_unit #(
  parameter int GRID_SIDE = 32,
  parameter int CAPACITY = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [pdoq_pkg::COORD_W-1:0]        in_cell_x,
  input  logic [pdoq_pkg::COORD_W-1:0]        in_cell_y,
  input  logic signed [pdoq_pkg::HEIGHT_W-1:0] in_centre_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pdoq_pkg::STATUS_W-1:0]       out_status,
  output logic [pdoq_pkg::COORD_W-1:0]        out_x,
  output logic [pdoq_pkg::COORD_W-1:0]        out_y,
  output logic signed [pdoq_pkg::DEPTH_W-1:0] out_depth,
  output logic                                out_last_entry,
  input  logic                                cfg_we,
  input  logic [pdoq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdoq_pkg::COEF_W-1:0]         cfg_data
);

  localparam int CW = pdoq_pkg::COORD_W;
  localparam int COORD_MAX = (1 << CW) - 1;
  // widest raster index the 5-bit coordinates can form at this grid size
  localparam int RASTER_W = $clog2(COORD_MAX * GRID_SIDE + COORD_MAX + 1);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // coefficients
  pdoq_pkg::coef_t coef_r, coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pdoq_pkg::CFG_DEPTH_X: coef_nxt.cx = cfg_data;
        pdoq_pkg::CFG_DEPTH_Y: coef_nxt.cy = cfg_data;
        pdoq_pkg::CFG_DEPTH_H: coef_nxt.ch = cfg_data;
        default: ;
      endcase
    end
  end

  // request pipeline: stage 1 holds products, stage 2 holds the depth
  logic          s1_r, s1_nxt;
  logic          s2_r, s2_nxt;
  logic          req_r;
  logic [CW-1:0] x_r, y_r;
  logic          accept;
  logic          apply;
  logic          out_valid_r, out_valid_nxt;

  assign in_stall = s1_r | s2_r;
  assign accept = in_valid & ~in_stall;
  // row update once the output register is free or emptying now
  assign apply = s2_r & (~out_valid_r | ~out_stall);

  always_comb begin
    s1_nxt = accept;
    s2_nxt = s1_r | (s2_r & ~apply);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      x_r <= in_cell_x;
      y_r <= in_cell_y;
    end
  end

  logic [pdoq_pkg::DEPTH_W-1:0] new_depth;

  pdoq_depth u_depth (
    .clk     (clk),
    .load_en (accept),
    .sum_en  (s1_r),
    .coef    (coef_r),
    .cell_x  (in_cell_x),
    .cell_y  (in_cell_y),
    .height  (in_centre_height),
    .depth   (new_depth)
  );

  // entry count and request decode
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             is_full, is_empty;
  pdoq_pkg::cell_ctl_t ctl;

  assign is_full = (count_r >= CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    ctl.insert = apply & (req_r == pdoq_pkg::REQ_INSERT) & ~is_full;
    ctl.pop = apply & (req_r == pdoq_pkg::REQ_POP) & ~is_empty;
    count_nxt = count_r;
    if (ctl.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // cell row, head at index 0
  pdoq_pkg::entry_t    new_ent;
  logic [RASTER_W-1:0] new_ras;
  pdoq_pkg::entry_t    ent [CAPACITY];
  logic [RASTER_W-1:0] ras [CAPACITY];
  logic                vld [CAPACITY];
  logic                flg [CAPACITY];

  assign new_ent = '{x: x_r, y: y_r, depth: new_depth};
  assign new_ras = RASTER_W'(y_r) * RASTER_W'(GRID_SIDE) + RASTER_W'(x_r);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                prev_flag, prev_valid, next_valid;
    pdoq_pkg::entry_t    prev_ent, next_ent;
    logic [RASTER_W-1:0] prev_ras, next_ras;

    if (i == 0) begin : g_head
      assign prev_flag = 1'b0;
      assign prev_valid = 1'b0;
      assign prev_ent = '0;
      assign prev_ras = '0;
    end else begin : g_body
      assign prev_flag = flg[i-1];
      assign prev_valid = vld[i-1];
      assign prev_ent = ent[i-1];
      assign prev_ras = ras[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_ent = '0;
      assign next_ras = '0;
    end else begin : g_link
      assign next_valid = vld[i+1];
      assign next_ent = ent[i+1];
      assign next_ras = ras[i+1];
    end

    pdoq_cell #(.RASTER_W(RASTER_W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_ent    (new_ent),
      .new_ras    (new_ras),
      .prev_flag  (prev_flag),
      .prev_valid (prev_valid),
      .prev_ent   (prev_ent),
      .prev_ras   (prev_ras),
      .next_valid (next_valid),
      .next_ent   (next_ent),
      .next_ras   (next_ras),
      .flag       (flg[i]),
      .valid      (vld[i]),
      .ent        (ent[i]),
      .ras        (ras[i])
    );
  end

  // output register
  logic [pdoq_pkg::STATUS_W-1:0] status_r, status_nxt;
  pdoq_pkg::entry_t              res_r, res_nxt;
  logic                          last_r, last_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r & ~out_stall) begin
      out_valid_nxt = 1'b0;
    end
    res_nxt = '0;
    last_nxt = 1'b0;
    if (req_r == pdoq_pkg::REQ_INSERT) begin
      status_nxt = is_full ? pdoq_pkg::ST_DROP_FULL : pdoq_pkg::ST_INSERTED;
    end else if (is_empty) begin
      status_nxt = pdoq_pkg::ST_POP_EMPTY;
    end else begin
      status_nxt = pdoq_pkg::ST_POPPED;
      res_nxt = ent[0];
      last_nxt = (count_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      s1_r <= 1'b0;
      s2_r <= 1'b0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      coef_r <= coef_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      status_r <= status_nxt;
      res_r <= res_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_x = res_r.x;
  assign out_y = res_r.y;
  assign out_depth = $signed(res_r.depth);
  assign out_last_entry = last_r;

endmodule

// ----- sv/pdoq_checker.sv -----
module pdoq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [pdoq_pkg::STATUS_W-1:0]       out_status,
  input logic [pdoq_pkg::COORD_W-1:0]        out_x,
  input logic [pdoq_pkg::COORD_W-1:0]        out_y,
  input logic signed [pdoq_pkg::DEPTH_W-1:0] out_depth,
  input logic                                out_last_entry
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_depth)
      && $stable(out_x) && $stable(out_y) && $stable(out_last_entry))
    else $error("stalled result changed");

  // only a successful pop carries a cell
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pdoq_pkg::ST_POPPED) |->
      out_x == '0 && out_y == '0 && out_depth == '0 && !out_last_entry)
    else $error("non-pop result carries data");

  // an accepted request keeps the input closed while its depth is formed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  // a result never shows up right after an accept made while none was showing
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind painter_depth_order_queue_unit pdoq_checker u_pdoq_checker (.*);

// ----- tb/sv/painter_depth_order_queue_unit_test.sv -----
module painter_depth_order_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pdoq_pkg::*;

  localparam int GRID_SIDE = 32;
  localparam int CAPACITY = 1024;
  // no acceptance on either side for this many cycles means the block hung;
  // the longest legal quiet stretch is the receiver hold-off below
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  // extra cycles after the last pending result, to catch stray beats
  localparam int DRAIN_CYCLES = 6;

  // one result beat as the predictor sees it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [DEPTH_W-1:0]  depth;
    logic                last;
  } painter_beat_t;

  // directed script: a request checked by the predictor, a request with its
  // result typed in, or a coefficient write
  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COEF_W-1:0]    cfg_val;
    logic                 req;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [HEIGHT_W-1:0]  h;
    painter_beat_t        want;
  } stim_row_t;

  localparam painter_beat_t EMPTY_BEAT = '{ST_POP_EMPTY, 5'd0, 5'd0, 48'd0, 1'b0};
  localparam painter_beat_t INSERTED_BEAT = '{ST_INSERTED, 5'd0, 5'd0, 48'd0, 1'b0};

  localparam int SCRIPT_LEN = 30;
  localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
    // all coefficients zero after reset: every depth is 0, raster decides
    '{ROW_TYPED, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, EMPTY_BEAT},
    // pop on empty with every pop field bit set: fields are ignored
    '{ROW_TYPED, '0, '0, REQ_POP, 5'd31, 5'd31, 16'hFFFF, EMPTY_BEAT},
    '{ROW_TYPED, '0, '0, REQ_INSERT, 5'd0, 5'd0, 16'h0000, INSERTED_BEAT},
    '{ROW_TYPED, '0, '0, REQ_INSERT, 5'd31, 5'd31, 16'h8000, INSERTED_BEAT},
    // same cell again: full tie, pops in insertion order
    '{ROW_TYPED, '0, '0, REQ_INSERT, 5'd31, 5'd31, 16'h7FFF, INSERTED_BEAT},
    '{ROW_TYPED, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000,
      '{ST_POPPED, 5'd0, 5'd0, 48'd0, 1'b0}},
    '{ROW_TYPED, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000,
      '{ST_POPPED, 5'd31, 5'd31, 48'd0, 1'b0}},
    '{ROW_TYPED, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000,
      '{ST_POPPED, 5'd31, 5'd31, 48'd0, 1'b1}},
    '{ROW_TYPED, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, EMPTY_BEAT},
    // coefficient extremes, one sign mix
    '{ROW_CFG, CFG_DEPTH_X, 32'h7FFF_FFFF, REQ_INSERT, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_CFG, CFG_DEPTH_Y, 32'h8000_0000, REQ_INSERT, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_CFG, CFG_DEPTH_H, 32'h7FFF_FFFF, REQ_INSERT, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_PREDICT, '0, '0, REQ_INSERT, 5'd31, 5'd0, 16'h7FFF, '0},
    '{ROW_PREDICT, '0, '0, REQ_INSERT, 5'd0, 5'd31, 16'h8000, '0},
    '{ROW_PREDICT, '0, '0, REQ_INSERT, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_PREDICT, '0, '0, REQ_INSERT, 5'd31, 5'd31, 16'h0001, '0},
    '{ROW_PREDICT, '0, '0, REQ_POP, 5'd21, 5'd10, 16'h5555, '0},
    '{ROW_PREDICT, '0, '0, REQ_POP, 5'd10, 5'd21, 16'hAAAA, '0},
    '{ROW_PREDICT, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_PREDICT, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, '0},
    // the opposite sign mix
    '{ROW_CFG, CFG_DEPTH_X, 32'h8000_0000, REQ_INSERT, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_CFG, CFG_DEPTH_Y, 32'h7FFF_FFFF, REQ_INSERT, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_CFG, CFG_DEPTH_H, 32'h8000_0000, REQ_INSERT, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_PREDICT, '0, '0, REQ_INSERT, 5'd0, 5'd0, 16'h8000, '0},
    '{ROW_PREDICT, '0, '0, REQ_INSERT, 5'd31, 5'd31, 16'h7FFF, '0},
    '{ROW_PREDICT, '0, '0, REQ_INSERT, 5'd5, 5'd9, 16'h0000, '0},
    '{ROW_PREDICT, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_PREDICT, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_PREDICT, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, '0},
    '{ROW_TYPED, '0, '0, REQ_POP, 5'd0, 5'd0, 16'h0000, EMPTY_BEAT}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_stall;
  logic                 in_req_type;
  logic [COORD_W-1:0]   in_cell_x;
  logic [COORD_W-1:0]   in_cell_y;
  logic signed [HEIGHT_W-1:0] in_centre_height;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic [COORD_W-1:0]   out_x;
  logic [COORD_W-1:0]   out_y;
  logic signed [DEPTH_W-1:0] out_depth;
  logic                 out_last_entry;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  // predictor state: coefficients and the store in paint order, head first
  coef_t         model_coef;
  entry_t        paint_order[$];
  painter_beat_t pending_beats[$];

  int  mismatch_count = 0;
  int  beat_count = 0;
  int  quiet_cycles = 0;
  // idling knobs for the sender and receiver processes
  bit  send_gaps;
  bit  recv_gaps;
  bit  hold_req;

  painter_depth_order_queue_unit #(
    .GRID_SIDE(GRID_SIDE),
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .in_centre_height(in_centre_height),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_depth       (out_depth),
    .out_last_entry  (out_last_entry),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // deeper first; equal depth goes to the lower raster index. A full tie
  // returns 0, so a new entry lands behind its equals (insertion order).
  function automatic bit paints_first(entry_t a, entry_t b);
    int ra;
    int rb;
    ra = int'(a.y) * GRID_SIDE + int'(a.x);
    rb = int'(b.y) * GRID_SIDE + int'(b.x);
    if ($signed(a.depth) != $signed(b.depth)) begin
      return $signed(a.depth) > $signed(b.depth);
    end
    return ra < rb;
  endfunction

  // advance the store by one request and return the beat it must produce
  function automatic painter_beat_t paint_order_step(logic req, logic [COORD_W-1:0] x,
                                                     logic [COORD_W-1:0] y,
                                                     logic [HEIGHT_W-1:0] h);
    painter_beat_t beat;
    entry_t        ent;
    longint        depth;
    int            slot;
    beat = '0;
    if (req == REQ_INSERT) begin
      if (paint_order.size() >= CAPACITY) begin
        beat.status = ST_DROP_FULL;
      end else begin
        // (2x+1) is the cell center doubled; all three terms land in 2^-17
        depth = longint'($signed(model_coef.cx)) * longint'(2 * int'(x) + 1)
              + longint'($signed(model_coef.cy)) * longint'(2 * int'(y) + 1)
              + longint'($signed(model_coef.ch)) * longint'($signed(h));
        ent.x = x;
        ent.y = y;
        ent.depth = depth[DEPTH_W-1:0];
        slot = 0;
        while (slot < paint_order.size() && !paints_first(ent, paint_order[slot])) begin
          slot++;
        end
        paint_order.insert(slot, ent);
        beat.status = ST_INSERTED;
      end
    end else if (paint_order.size() == 0) begin
      beat.status = ST_POP_EMPTY;
    end else begin
      ent = paint_order.pop_front();
      beat.status = ST_POPPED;
      beat.x = ent.x;
      beat.y = ent.y;
      beat.depth = ent.depth;
      beat.last = (paint_order.size() == 0);
    end
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic logic [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one request beat, hold it until taken, then log its expected result.
  // The typed result, when given, stands in for the predicted one.
  task automatic send_request(input logic req, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [HEIGHT_W-1:0] h,
                              input bit typed, input painter_beat_t want);
    painter_beat_t predicted;
    int            gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_cell_x <= x;
    in_cell_y <= y;
    in_centre_height <= h;
    do @(posedge clk); while (in_stall);
    predicted = paint_order_step(req, x, y, h);
    pending_beats.push_back(typed ? want : predicted);
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_DEPTH_X: model_coef.cx = val;
      CFG_DEPTH_Y: model_coef.cy = val;
      CFG_DEPTH_H: model_coef.ch = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] cx, input logic [COEF_W-1:0] cy,
                           input logic [COEF_W-1:0] ch);
    wait_drained();
    write_coef(CFG_DEPTH_X, cx);
    write_coef(CFG_DEPTH_Y, cy);
    write_coef(CFG_DEPTH_H, ch);
  endtask

  // small signed coefficient, so that depths collide often
  function automatic logic [COEF_W-1:0] tiny_coef();
    int k;
    k = $urandom_range(0, 4);
    k -= 2;
    return k;
  endfunction

  // Random insert/pop mix. In tie-heavy mode heights stay tiny and a quarter
  // of the requests repeat the previous cell, to stress the tie-break rules.
  task automatic run_mix(input int count, input int insert_pct, input bit tie_heavy);
    logic               req;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [HEIGHT_W-1:0] h;
    x = '0;
    y = '0;
    h = '0;
    repeat (count) begin
      req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP;
      if (!tie_heavy || $urandom_range(0, 3) != 0) begin
        x = 5'($urandom);
        y = 5'($urandom);
        h = tie_heavy ? 16'($urandom_range(0, 3)) : pick_height();
      end
      send_request(req, x, y, h, 1'b0, '0);
    end
  endtask

  task automatic send_random_insert();
    send_request(REQ_INSERT, 5'($urandom), 5'($urandom), pick_height(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] result beat %0d, %s: got %0h, want %0h",
             $time, beat_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    painter_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending, status", 64'(out_status), '0);
      end else begin
        want = pending_beats.pop_front();
        check_field("status", 64'(out_status), 64'(want.status));
        check_field("x", 64'(out_x), 64'(want.x));
        check_field("y", 64'(out_y), 64'(want.y));
        check_field("depth", {16'b0, out_depth}, {16'b0, want.depth});
        check_field("last_entry", 64'(out_last_entry), 64'(want.last));
      end
      beat_count++;
    end
  end

  // hang detector: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_INSERT;
    in_cell_x = '0;
    in_cell_y = '0;
    in_centre_height = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEPTH_X;
    cfg_data = '0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    hold_req = 1'b0;
    model_coef = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed script
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        wait_drained();
        write_coef(SCRIPT[i].cfg_idx, SCRIPT[i].cfg_val);
      end else begin
        send_request(SCRIPT[i].req, SCRIPT[i].x, SCRIPT[i].y, SCRIPT[i].h,
                     SCRIPT[i].kind == ROW_TYPED, SCRIPT[i].want);
      end
    end

    // wide random coefficients, store grows slowly
    set_coefs($urandom, $urandom, $urandom);
    run_mix(250, 60, 1'b0);

    // tiny coefficients: lots of depth ties and repeated cells; the sender
    // pauses midway until the block has answered everything
    set_coefs(tiny_coef(), tiny_coef(), tiny_coef());
    run_mix(120, 55, 1'b1);
    wait_drained();
    run_mix(130, 55, 1'b1);

    // fill to capacity under a long receiver hold-off, overflow, then drain
    set_coefs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    hold_req = 1'b1;
    send_gaps = 1'b0;
    repeat (40) send_random_insert();
    send_gaps = 1'b1;
    while (paint_order.size() < CAPACITY) send_random_insert();
    repeat (6) send_random_insert();
    send_request(REQ_POP, 5'($urandom), 5'($urandom), pick_height(), 1'b0, '0);
    repeat (2) send_random_insert();
    while (paint_order.size() > 0) begin
      send_request(REQ_POP, 5'($urandom), 5'($urandom), pick_height(), 1'b0, '0);
    end
    repeat (2) send_request(REQ_POP, 5'($urandom), 5'($urandom), pick_height(), 1'b0, '0);

    // last stretch at full rate on both sides
    set_coefs($urandom, $urandom, $urandom);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_mix(200, 50, 1'b0);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
